/* sv/rsig_pkg.sv */
// ----------------------------------------------------------------------------
// rsig_pkg
// Shared constants and types for the raster sync interrupt generator:
// register indexes, hblank match modes and register reset values.
// ----------------------------------------------------------------------------
package rsig_pkg;

   localparam int COORD_BITS_DEFAULT = 10;
   localparam int REG_BITS           = 10;
   localparam int CSR_INDEX_BITS     = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LINE_LENGTH    = 3'd0,
      CSR_FRAME_LINES    = 3'd1,
      CSR_HBLANK_MODE    = 3'd2,
      CSR_HBLANK_COMPARE = 3'd3,
      CSR_VBLANK_IN      = 3'd4,
      CSR_VBLANK_OUT     = 3'd5,
      CSR_PIXEL_DIVIDE   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      HB_MODE_LINE     = 2'd0,
      HB_MODE_INTERVAL = 2'd1,
      HB_MODE_ALL      = 2'd2,
      HB_MODE_NONE     = 2'd3
   } hblank_mode_type;

   localparam logic [REG_BITS-1:0] LINE_LENGTH_RESET = 10'h359;
   localparam logic [REG_BITS-1:0] FRAME_LINES_RESET = 10'h106;
   localparam logic [REG_BITS-1:0] HB_COMPARE_RESET  = 10'h000;
   localparam logic [REG_BITS-1:0] VBLANK_IN_RESET   = 10'h104;
   localparam logic [REG_BITS-1:0] VBLANK_OUT_RESET  = 10'h015;
   localparam logic [1:0]          PIXEL_DIV_RESET   = 2'd2;

endpackage

/* sv/raster_sync_interrupt_generator_core.sv */
// ----------------------------------------------------------------------------
// raster_sync_interrupt_generator_core
// Raster position counters with hblank / vblank-in / vblank-out interrupt
// pulses, at most one video clock tick per transaction.
// ----------------------------------------------------------------------------
// Responses are registered: rsp_* come from the output buffer entry.
// Throughput: 1 transaction per cycle while req_stall is low; a two-entry
// response buffer keeps the request side moving while one response waits.
// Writing hblank_compare starts a bit-serial remainder pass that rebuilds the
// line interval phase; requests stall meanwhile.
// Reset (synchronous): raster at column 0 row 0, registers at defaults.
module raster_sync_interrupt_generator_core #(
   parameter int COORD_BITS = rsig_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_tick,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hblank_irq,
   output logic                                 rsp_vblank_in_irq,
   output logic                                 rsp_vblank_out_irq,
   output logic [COORD_BITS-1:0]                rsp_raster_column,
   output logic [COORD_BITS-1:0]                rsp_raster_row,
   input  logic                                 csr_write,
   input  logic [rsig_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rsig_pkg::REG_BITS-1:0]        csr_data
);
   import rsig_pkg::*;

   localparam int CMP_BITS = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
   localparam int DIVD_BITS = COORD_BITS + 1;
   localparam int CNT_BITS = $clog2(DIVD_BITS + 1);

   typedef struct packed {
      logic                  hblank;
      logic                  vblank_in;
      logic                  vblank_out;
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
   } result_type;

   // configuration registers
   logic [REG_BITS-1:0] line_len_ff, frame_lines_ff, hb_cmp_ff, vin_line_ff, vout_line_ff;
   hblank_mode_type     hb_mode_ff;
   logic [1:0]          pix_div_ff;

   // raster state
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  pix_phase_ff, pix_phase_in;
   logic [REG_BITS-1:0]   ivl_phase_ff, ivl_phase_in;

   // remainder unit
   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [REG_BITS:0]     rem_ff, rem_in;
   logic [DIVD_BITS-1:0]  divd_ff, divd_in;
   logic [REG_BITS:0]     rem_trial;

   // response buffer
   result_type out_ff, out_in, skid_ff, skid_in, result;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic req_accept, rsp_accept, advance, col_wrap, row_wrap, hb_match;
   logic cmp_write;
   logic [REG_BITS-1:0] ivl_inc;

   assign req_stall  = skid_valid_ff | busy_ff;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_accept = out_valid_ff & ~rsp_stall;

   assign rsp_hblank_irq     = out_ff.hblank;
   assign rsp_vblank_in_irq  = out_ff.vblank_in;
   assign rsp_vblank_out_irq = out_ff.vblank_out;
   assign rsp_raster_column  = out_ff.column;
   assign rsp_raster_row     = out_ff.row;

   assign cmp_write = csr_write & (csr_index == CSR_HBLANK_COMPARE);

   // divide-by-one (or zero) advances every tick, otherwise every other tick
   assign advance = req_accept & req_tick & (~pix_div_ff[1] | pix_phase_ff);

   always_comb begin
      col_wrap = CMP_BITS'(column_ff) >= CMP_BITS'(line_len_ff);
      row_wrap = CMP_BITS'(row_ff) >= CMP_BITS'(frame_lines_ff);

      pix_phase_in = pix_phase_ff;
      if (req_accept && req_tick) begin
         pix_phase_in = pix_div_ff[1] & ~pix_phase_ff;
      end

      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (col_wrap) begin
            column_in = '0;
            row_in    = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            column_in = column_ff + 1'b1;
         end
      end

      // interval phase tracks (row + 1) mod hblank_compare
      ivl_inc = (ivl_phase_ff + 1'b1 == hb_cmp_ff) ? '0 : ivl_phase_ff + 1'b1;
      ivl_phase_in = ivl_phase_ff;
      if (busy_ff && cnt_ff == CNT_BITS'(1)) begin
         ivl_phase_in = rem_in[REG_BITS-1:0];
      end else if (advance && col_wrap) begin
         if (row_in == '0) begin
            ivl_phase_in = (hb_cmp_ff == REG_BITS'(1)) ? '0 : REG_BITS'(1);
         end else begin
            ivl_phase_in = ivl_inc;
         end
      end

      unique case (hb_mode_ff)
         HB_MODE_LINE:     hb_match = CMP_BITS'(row_in) == CMP_BITS'(hb_cmp_ff);
         HB_MODE_INTERVAL: hb_match = (hb_cmp_ff != '0) && (ivl_phase_in == '0);
         HB_MODE_ALL:      hb_match = 1'b1;
         HB_MODE_NONE:     hb_match = 1'b0;
         default:          hb_match = 1'b0;
      endcase

      result.hblank     = advance & col_wrap & hb_match;
      result.vblank_in  = advance & col_wrap &
                          (CMP_BITS'(row_in) == CMP_BITS'(vin_line_ff));
      result.vblank_out = advance & col_wrap &
                          (CMP_BITS'(row_in) == CMP_BITS'(vout_line_ff));
      result.column     = column_in;
      result.row        = row_in;
   end

   // restoring remainder of (row + 1) by hblank_compare, one bit per cycle
   always_comb begin
      rem_trial = {rem_ff[REG_BITS-1:0], divd_ff[DIVD_BITS-1]};
      rem_in    = rem_ff;
      divd_in   = divd_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (cmp_write) begin
         rem_in  = '0;
         divd_in = DIVD_BITS'(row_ff) + 1'b1;
         cnt_in  = CNT_BITS'(DIVD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = (rem_trial >= {1'b0, hb_cmp_ff}) ? rem_trial - {1'b0, hb_cmp_ff}
                                                     : rem_trial;
         divd_in = {divd_ff[DIVD_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_BITS'(1);
      end
   end

   // two-entry response buffer
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_accept) begin
         out_valid_in = skid_valid_ff;
         out_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (!out_valid_ff || rsp_accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff    <= LINE_LENGTH_RESET;
         frame_lines_ff <= FRAME_LINES_RESET;
         hb_mode_ff     <= HB_MODE_LINE;
         hb_cmp_ff      <= HB_COMPARE_RESET;
         vin_line_ff    <= VBLANK_IN_RESET;
         vout_line_ff   <= VBLANK_OUT_RESET;
         pix_div_ff     <= PIXEL_DIV_RESET;
         column_ff      <= '0;
         row_ff         <= '0;
         pix_phase_ff   <= 1'b0;
         ivl_phase_ff   <= '0;
         busy_ff        <= 1'b0;
         cnt_ff         <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LINE_LENGTH:    line_len_ff    <= csr_data;
               CSR_FRAME_LINES:    frame_lines_ff <= csr_data;
               CSR_HBLANK_MODE:    hb_mode_ff     <= hblank_mode_type'(csr_data[1:0]);
               CSR_HBLANK_COMPARE: hb_cmp_ff      <= csr_data;
               CSR_VBLANK_IN:      vin_line_ff    <= csr_data;
               CSR_VBLANK_OUT:     vout_line_ff   <= csr_data;
               CSR_PIXEL_DIVIDE:   pix_div_ff     <= csr_data[1:0];
               default:            ;
            endcase
         end
         column_ff     <= column_in;
         row_ff        <= row_in;
         pix_phase_ff  <= pix_phase_in;
         ivl_phase_ff  <= ivl_phase_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      divd_ff <= divd_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for raster_sync_interrupt_generator_core. A queue of
// tick transactions feeds a clocked driver with random gaps, and the response
// side stalls at random, once for a long stretch. Every accepted tick is run
// through a raster model kept in the bench. Each response is compared field
// by field with the oldest predicted one. Registers are rewritten between
// phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
   import rsig_pkg::*;

   localparam int COORD = COORD_BITS_DEFAULT;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;
   localparam int unsigned LONG_HOLD = 80;

   typedef struct packed {
      logic             hblank_irq;
      logic             vblank_in_irq;
      logic             vblank_out_irq;
      logic [COORD-1:0] column;
      logic [COORD-1:0] row;
   } raster_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_tick = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hblank_irq;
   logic rsp_vblank_in_irq;
   logic rsp_vblank_out_irq;
   logic [COORD-1:0] rsp_raster_column;
   logic [COORD-1:0] rsp_raster_row;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [REG_BITS-1:0] csr_data = '0;

   raster_sync_interrupt_generator_core #(.COORD_BITS(COORD)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_tick           (req_tick),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hblank_irq     (rsp_hblank_irq),
      .rsp_vblank_in_irq  (rsp_vblank_in_irq),
      .rsp_vblank_out_irq (rsp_vblank_out_irq),
      .rsp_raster_column  (rsp_raster_column),
      .rsp_raster_row     (rsp_raster_row),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // raster model: registers and state
   logic [REG_BITS-1:0] line_last;
   logic [REG_BITS-1:0] frame_last;
   hblank_mode_type     hb_mode;
   logic [REG_BITS-1:0] hb_compare;
   logic [REG_BITS-1:0] vin_line;
   logic [REG_BITS-1:0] vout_line;
   logic [1:0]          pixel_div;
   logic [COORD-1:0]    column_pos;
   logic [COORD-1:0]    row_pos;
   logic                pixel_half;
   logic [REG_BITS-1:0] line_interval_phase;

   logic              tick_queue[$];
   raster_result_type expected_results[$];
   int unsigned       accepted_ticks = 0;
   int unsigned       mismatches = 0;
   logic              steady = 1'b0;
   int unsigned       send_gap = 0;
   int unsigned       stall_left = 0;
   logic              long_hold_done = 1'b0;

   function automatic void reset_raster_model();
      line_last           = LINE_LENGTH_RESET;
      frame_last          = FRAME_LINES_RESET;
      hb_mode             = HB_MODE_LINE;
      hb_compare          = HB_COMPARE_RESET;
      vin_line            = VBLANK_IN_RESET;
      vout_line           = VBLANK_OUT_RESET;
      pixel_div           = PIXEL_DIV_RESET;
      column_pos          = '0;
      row_pos             = '0;
      pixel_half          = 1'b0;
      line_interval_phase = '0;
   endfunction

   function automatic logic row_hits_hblank(logic [COORD-1:0] row);
      logic [COORD:0] row_plus;
      row_plus = {1'b0, row} + 1'b1;
      case (hb_mode)
         HB_MODE_LINE:     return row == hb_compare;
         HB_MODE_INTERVAL: return (hb_compare != 0) && ((row_plus % {1'b0, hb_compare}) == 0);
         HB_MODE_ALL:      return 1'b1;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic raster_result_type advance_raster(logic tick);
      raster_result_type res;
      logic              step;
      logic [COORD:0]    row_plus;
      res  = '0;
      step = 1'b0;
      if (tick) begin
         if (pixel_div >= 2) begin
            step       = pixel_half;
            pixel_half = ~pixel_half;
         end else begin
            step       = 1'b1;
            pixel_half = 1'b0;
         end
      end
      if (step) begin
         // counters wrap whenever they sit at or above their limit
         if (column_pos >= line_last) begin
            column_pos = '0;
            row_pos    = (row_pos >= frame_last) ? '0 : row_pos + 1'b1;
            res.hblank_irq     = row_hits_hblank(row_pos);
            res.vblank_in_irq  = row_pos == vin_line;
            res.vblank_out_irq = row_pos == vout_line;
         end else begin
            column_pos = column_pos + 1'b1;
         end
         row_plus = {1'b0, row_pos} + 1'b1;
         if (hb_compare != 0)
            line_interval_phase = REG_BITS'(row_plus % {1'b0, hb_compare});
         else
            line_interval_phase = '0;
      end
      res.column = column_pos;
      res.row    = row_pos;
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0)
         steady <= ~steady;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (tick_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_tick  <= tick_queue.pop_front();
            send_gap  <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with one long hold-off so the block backs up
   always @(posedge clock) begin : rsp_side
      int unsigned gap;
      if (reset) begin
         rsp_stall      <= 1'b0;
         stall_left     <= 0;
         long_hold_done <= 1'b0;
      end else if (!long_hold_done && accepted_ticks >= 200) begin
         rsp_stall      <= 1'b1;
         stall_left     <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         gap        = pick_gap();
         rsp_stall  <= gap != 0;
         stall_left <= (gap != 0) ? gap - 1 : 0;
      end
   end

   // predict on each accepted tick, then check each accepted response
   always @(posedge clock) begin : monitor
      raster_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(advance_raster(req_tick));
            accepted_ticks <= accepted_ticks + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response with no transaction pending");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_hblank_irq !== want.hblank_irq) begin
                  $error("hblank_irq: expected %0d, actual %0d", want.hblank_irq,
                         rsp_hblank_irq);
                  mismatches++;
               end
               if (rsp_vblank_in_irq !== want.vblank_in_irq) begin
                  $error("vblank_in_irq: expected %0d, actual %0d", want.vblank_in_irq,
                         rsp_vblank_in_irq);
                  mismatches++;
               end
               if (rsp_vblank_out_irq !== want.vblank_out_irq) begin
                  $error("vblank_out_irq: expected %0d, actual %0d", want.vblank_out_irq,
                         rsp_vblank_out_irq);
                  mismatches++;
               end
               if (rsp_raster_column !== want.column) begin
                  $error("raster_column: expected %0d, actual %0d", want.column,
                         rsp_raster_column);
                  mismatches++;
               end
               if (rsp_raster_row !== want.row) begin
                  $error("raster_row: expected %0d, actual %0d", want.row, rsp_raster_row);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [REG_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      case (index)
         CSR_LINE_LENGTH:    line_last  = data;
         CSR_FRAME_LINES:    frame_last = data;
         CSR_HBLANK_MODE:    hb_mode    = hblank_mode_type'(data[1:0]);
         CSR_HBLANK_COMPARE: hb_compare = data;
         CSR_VBLANK_IN:      vin_line   = data;
         CSR_VBLANK_OUT:     vout_line  = data;
         CSR_PIXEL_DIVIDE:   pixel_div  = data[1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic queue_ticks(input int unsigned count, input int unsigned pct_one);
      for (int unsigned i = 0; i < count; i++)
         tick_queue.push_back($urandom_range(0, 99) < pct_one);
   endtask

   // sampled mid-cycle so the driver and monitor updates of the edge are settled
   task automatic drain_pipeline();
      do
         @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic random_settings(input int unsigned phase);
      logic [REG_BITS-1:0] line, frame;
      line  = ($urandom_range(0, 7) == 0) ? REG_BITS'($urandom) : REG_BITS'($urandom_range(0, 6));
      frame = ($urandom_range(0, 7) == 0) ? REG_BITS'($urandom) : REG_BITS'($urandom_range(0, 8));
      case (phase)
         2: begin
            line  = '0;
            frame = '0;
         end
         5: begin
            line  = '1;
            frame = '1;
         end
         default: ;
      endcase
      write_csr(CSR_LINE_LENGTH, line);
      write_csr(CSR_FRAME_LINES, frame);
      write_csr(CSR_HBLANK_MODE, REG_BITS'($urandom));
      write_csr(CSR_HBLANK_COMPARE, ($urandom_range(0, 5) == 0) ? REG_BITS'($urandom) :
                REG_BITS'($urandom_range(0, 10)));
      write_csr(CSR_VBLANK_IN, ($urandom_range(0, 5) == 0) ? REG_BITS'($urandom) :
                REG_BITS'($urandom_range(0, 9)));
      write_csr(CSR_VBLANK_OUT, ($urandom_range(0, 5) == 0) ? REG_BITS'($urandom) :
                REG_BITS'($urandom_range(0, 9)));
      write_csr(CSR_PIXEL_DIVIDE, ($urandom_range(0, 4) == 0) ? REG_BITS'($urandom) :
                REG_BITS'($urandom_range(1, 2)));
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_SPARE, REG_BITS'($urandom));
   endtask

   initial begin
      reset_raster_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values, divide by two
      tick_queue = '{1'b0, 1'b1, 1'b1, 1'b1};
      drain_pipeline();

      // one pixel per line, every row matches hblank
      write_csr(CSR_LINE_LENGTH, 10'd0);
      write_csr(CSR_FRAME_LINES, 10'd2);
      write_csr(CSR_HBLANK_MODE, REG_BITS'(HB_MODE_ALL));
      write_csr(CSR_HBLANK_COMPARE, 10'd0);
      write_csr(CSR_VBLANK_IN, 10'd2);
      write_csr(CSR_VBLANK_OUT, 10'd0);
      write_csr(CSR_PIXEL_DIVIDE, 10'd1);
      queue_ticks(5, 100);
      drain_pipeline();

      // interval mode with a zero interval never matches
      write_csr(CSR_HBLANK_MODE, REG_BITS'(HB_MODE_INTERVAL));
      queue_ticks(3, 100);
      drain_pipeline();

      // upper data bits dropped; divide of zero behaves as one
      write_csr(CSR_HBLANK_MODE, 10'h3ff);
      write_csr(CSR_PIXEL_DIVIDE, 10'd0);
      queue_ticks(3, 100);
      drain_pipeline();

      // divide of three behaves as two; unused index has no effect
      write_csr(CSR_SPARE, 10'h3ff);
      write_csr(CSR_HBLANK_MODE, REG_BITS'(HB_MODE_LINE));
      write_csr(CSR_HBLANK_COMPARE, 10'd2);
      write_csr(CSR_PIXEL_DIVIDE, 10'd3);
      queue_ticks(4, 100);
      drain_pipeline();

      // frame limit dropped below the current row
      write_csr(CSR_PIXEL_DIVIDE, 10'd1);
      write_csr(CSR_FRAME_LINES, 10'd8);
      queue_ticks(4, 100);
      drain_pipeline();
      write_csr(CSR_FRAME_LINES, 10'd1);
      queue_ticks(1, 100);
      drain_pipeline();

      // line limit dropped below the current column
      write_csr(CSR_LINE_LENGTH, 10'd6);
      queue_ticks(3, 100);
      drain_pipeline();
      write_csr(CSR_LINE_LENGTH, 10'd1);
      queue_ticks(1, 100);
      drain_pipeline();

      // 512-row frame, one pixel per line: reaches the last row and its wrap
      write_csr(CSR_LINE_LENGTH, 10'd0);
      write_csr(CSR_FRAME_LINES, 10'h1ff);
      write_csr(CSR_HBLANK_MODE, REG_BITS'(HB_MODE_INTERVAL));
      write_csr(CSR_HBLANK_COMPARE, 10'd256);
      write_csr(CSR_VBLANK_IN, 10'h1ff);
      write_csr(CSR_VBLANK_OUT, 10'd0);
      queue_ticks(520, 100);
      drain_pipeline();

      for (int unsigned phase = 0; phase < 12; phase++) begin
         random_settings(phase);
         queue_ticks(33, 85);
         drain_pipeline();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("raster_sync_interrupt_generator_core: match");
      else
         $display("raster_sync_interrupt_generator_core: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("raster_sync_interrupt_generator_core: mismatch");
      $finish;
   end

endmodule
